>>> sv/closest_point_on_segment_3d_top_assert.svh
// Assertion macros shared by the checker of the segment projection block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CLOSEST_POINT_ON_SEGMENT_3D_TOP_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_3D_TOP_ASSERT_SVH

// Implication in the same cycle, masked while reset is asserted.
`define CPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpseg assertion failed");

// Implication in the next cycle, masked while reset is asserted.
`define CPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpseg assertion failed");

// Implication in the next cycle that also holds across reset.
`define CPS_ASSERT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cpseg assertion failed");

`endif

>>> sv/cpseg_pkg.sv
// Shared widths, types and codes of the segment projection pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package cpseg_pkg;

    localparam int CW = 16;            // coordinate width, signed Q12.4
    localparam int TF = 16;            // fraction bits of the parameter t
    localparam int PW = 2 * CW + 2;    // signed product of two differences
    localparam int DW = 2 * CW + 4;    // signed dot product
    localparam int LW = 2 * CW + 2;    // unsigned squared length
    localparam int MW = TF + 1 + CW;   // t times a difference magnitude

    typedef enum logic [1:0] {
        TM_ZERO = 2'd0,
        TM_ONE  = 2'd1,
        TM_DIV  = 2'd2
    } tmode_t;

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] dmag;
        logic [2:0]         dneg;
        tmode_t             mode;
        logic               on_seg;
        logic               degen;
    } side_t;

endpackage

`default_nettype wire

>>> sv/cpseg_div.sv
// Pipelined restoring divider giving the fraction t = rem / len, one bit per stage.
// Depends on cpseg_pkg; the side word travels alongside each dividend.
`default_nettype none

module cpseg_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [cpseg_pkg::LW-1:0]      in_rem,
    input  wire logic [cpseg_pkg::LW-1:0]      in_len,
    input  wire cpseg_pkg::side_t              in_side,
    output logic                               out_valid,
    output logic [cpseg_pkg::TF-1:0]           out_q,
    output cpseg_pkg::side_t                   out_side
);

    localparam int N = cpseg_pkg::TF;
    localparam int L = cpseg_pkg::LW;

    logic                 v_reg    [N+1];
    logic [L-1:0]         rem_reg  [N+1];
    logic [L-1:0]         len_reg  [N+1];
    logic [N-1:0]         q_reg    [N+1];
    cpseg_pkg::side_t     side_reg [N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_rem;
            len_reg[0]  <= in_len;
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= N; i++) begin : g_step
        logic [L:0]   sh;
        logic [L:0]   diff;
        logic         ge;
        logic [L-1:0] rem_next;

        // The remainder stays below len, so the shifted value is below twice len.
        assign sh       = {rem_reg[i-1], 1'b0};
        assign diff     = sh - {1'b0, len_reg[i-1]};
        assign ge       = (sh >= {1'b0, len_reg[i-1]});
        assign rem_next = ge ? diff[L-1:0] : sh[L-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                len_reg[i]  <= len_reg[i-1];
                q_reg[i]    <= {q_reg[i-1][N-2:0], ge};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_q     = q_reg[N];
    assign out_side  = side_reg[N];

endmodule

`default_nettype wire

>>> sv/closest_point_on_segment_3d_top.sv
// Closest point on a 3D segment: fixed-point projection, clamp and interpolation.
// Throughput is one word per cycle unless a finished word is held at the output;
// the divider pipeline sets the depth.
// Reset (aresetn, synchronous, active low) clears every stage valid bit.
// Depends on cpseg_pkg and cpseg_div.
`default_nettype none

module closest_point_on_segment_3d_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_p_x,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_p_y,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_p_z,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_a_x,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_a_y,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_a_z,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_b_x,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_b_y,
    input  wire logic signed [cpseg_pkg::CW-1:0]    s_b_z,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [cpseg_pkg::CW-1:0]         m_q_x,
    output logic signed [cpseg_pkg::CW-1:0]         m_q_y,
    output logic signed [cpseg_pkg::CW-1:0]         m_q_z,
    output logic                                    m_on_segment,
    output logic                                    m_degenerate
);

    localparam int CW = cpseg_pkg::CW;
    localparam int TF = cpseg_pkg::TF;
    localparam int PW = cpseg_pkg::PW;
    localparam int DW = cpseg_pkg::DW;
    localparam int LW = cpseg_pkg::LW;
    localparam int MW = cpseg_pkg::MW;

    localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (TF - 1);
    localparam logic [TF:0]   T_ONE = {1'b1, {TF{1'b0}}};

    // The whole pipeline advances together. It only holds when a finished word
    // sits in the output register and the downstream side is not taking it, so
    // a new word is taken every cycle while the output drains.
    logic en;
    assign en      = !(m_valid && !m_ready);
    assign s_ready = en;

    // Stage 1: differences d = b - a and w = p - a, one bit wider than a coordinate.
    logic                    v1_reg;
    logic signed [CW-1:0]    a1_reg [3];
    logic signed [CW:0]      w1_reg [3];
    logic signed [CW:0]      d1_reg [3];
    logic signed [CW-1:0]    in_p [3];
    logic signed [CW-1:0]    in_a [3];
    logic signed [CW-1:0]    in_b [3];

    assign in_p[0] = s_p_x;
    assign in_p[1] = s_p_y;
    assign in_p[2] = s_p_z;
    assign in_a[0] = s_a_x;
    assign in_a[1] = s_a_y;
    assign in_a[2] = s_a_z;
    assign in_b[0] = s_b_x;
    assign in_b[1] = s_b_y;
    assign in_b[2] = s_b_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a1_reg[k] <= in_a[k];
                w1_reg[k] <= {in_p[k][CW-1], in_p[k]} - {in_a[k][CW-1], in_a[k]};
                d1_reg[k] <= {in_b[k][CW-1], in_b[k]} - {in_a[k][CW-1], in_a[k]};
            end
        end
    end

    // Stage 2: the per-axis products w*d for the dot product and d*d for the
    // squared length. Each is one signed multiplier of difference width.
    logic                    v2_reg;
    logic signed [CW-1:0]    a2_reg [3];
    logic signed [CW:0]      d2_reg [3];
    logic signed [PW-1:0]    pw2_reg [3];
    logic [2*CW-1:0]         pl2_reg [3];
    logic signed [PW-1:0]    sq_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = d1_reg[k] * d1_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a2_reg[k]  <= a1_reg[k];
                d2_reg[k]  <= d1_reg[k];
                pw2_reg[k] <= w1_reg[k] * d1_reg[k];
                pl2_reg[k] <= sq_next[k][2*CW-1:0];
            end
        end
    end

    // Stage 3: sums over the three axes. Both sums are exact at these widths.
    logic                    v3_reg;
    logic signed [CW-1:0]    a3_reg [3];
    logic signed [CW:0]      d3_reg [3];
    logic signed [DW-1:0]    dot3_reg;
    logic [LW-1:0]           len3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a3_reg[k] <= a2_reg[k];
                d3_reg[k] <= d2_reg[k];
            end
            dot3_reg <= {{(DW-PW){pw2_reg[0][PW-1]}}, pw2_reg[0]}
                      + {{(DW-PW){pw2_reg[1][PW-1]}}, pw2_reg[1]}
                      + {{(DW-PW){pw2_reg[2][PW-1]}}, pw2_reg[2]};
            len3_reg <= {2'b00, pl2_reg[0]} + {2'b00, pl2_reg[1]} + {2'b00, pl2_reg[2]};
        end
    end

    // Classification feeding the divider. A zero-length segment and a
    // projection before the start both give t = 0; a projection at or past the
    // end gives t = 1. Only the strictly interior case needs the quotient.
    logic signed [DW-1:0]    len_s;
    logic                    is_degen;
    logic                    is_before;
    logic                    is_after;
    logic                    is_end;
    cpseg_pkg::side_t        side_in;
    logic [LW-1:0]           rem_in;

    assign len_s     = $signed({{(DW-LW){1'b0}}, len3_reg});
    assign is_degen  = (len3_reg == '0);
    assign is_before = dot3_reg[DW-1];
    assign is_after  = (dot3_reg > len_s);
    assign is_end    = (dot3_reg == len_s);

    always_comb begin
        logic signed [CW:0] mg;
        for (int k = 0; k < 3; k++) begin
            mg                = d3_reg[k][CW] ? -d3_reg[k] : d3_reg[k];
            side_in.a[k]      = a3_reg[k];
            side_in.dmag[k]   = mg[CW-1:0];
            side_in.dneg[k]   = d3_reg[k][CW];
        end
        side_in.degen = is_degen;
        if (is_degen || is_before) begin
            side_in.mode   = cpseg_pkg::TM_ZERO;
            side_in.on_seg = 1'b0;
        end else if (is_after) begin
            side_in.mode   = cpseg_pkg::TM_ONE;
            side_in.on_seg = 1'b0;
        end else if (is_end) begin
            side_in.mode   = cpseg_pkg::TM_ONE;
            side_in.on_seg = 1'b1;
        end else begin
            side_in.mode   = cpseg_pkg::TM_DIV;
            side_in.on_seg = 1'b1;
        end
        rem_in = (side_in.mode == cpseg_pkg::TM_DIV) ? dot3_reg[LW-1:0] : '0;
    end

    // Divider: one input stage and one quotient bit per stage after it.
    logic                    dv_valid;
    logic [TF-1:0]           dv_q;
    cpseg_pkg::side_t        dv_side;

    cpseg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    (rem_in),
        .in_len    (len3_reg),
        .in_side   (side_in),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // Interpolation multiply: t times |d| per axis.
    logic [TF:0]             t_sel;
    logic                    v5_reg;
    logic [MW-1:0]           m5_reg [3];
    logic [CW-1:0]           a5_reg [3];
    logic [2:0]              neg5_reg;
    logic                    on5_reg;
    logic                    dg5_reg;

    always_comb begin
        case (dv_side.mode)
            cpseg_pkg::TM_ONE: t_sel = T_ONE;
            cpseg_pkg::TM_DIV: t_sel = {1'b0, dv_q};
            default:           t_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                m5_reg[k] <= t_sel * dv_side.dmag[k];
                a5_reg[k] <= dv_side.a[k];
            end
            neg5_reg <= dv_side.dneg;
            on5_reg  <= dv_side.on_seg;
            dg5_reg  <= dv_side.degen;
        end
    end

    // Output stage: round half away from zero on the magnitude, apply the sign
    // of d and add to a. The result always lies between a and b.
    logic                    out_v_reg;
    logic [CW-1:0]           q_reg [3];
    logic                    on_reg;
    logic                    dg_reg;
    logic [CW-1:0]           q_next [3];

    always_comb begin
        logic [MW-1:0] rnd;
        logic [CW:0]   rs;
        logic [CW:0]   off;
        logic [CW:0]   sum;
        for (int k = 0; k < 3; k++) begin
            rnd       = m5_reg[k] + HALF;
            rs        = {1'b0, rnd[TF +: CW]};
            off       = neg5_reg[k] ? -rs : rs;
            sum       = {a5_reg[k][CW-1], a5_reg[k]} + off;
            q_next[k] = sum[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                q_reg[k] <= q_next[k];
            end
            on_reg <= on5_reg;
            dg_reg <= dg5_reg;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_q_x        = q_reg[0];
    assign m_q_y        = q_reg[1];
    assign m_q_z        = q_reg[2];
    assign m_on_segment = on_reg;
    assign m_degenerate = dg_reg;

endmodule

`default_nettype wire

>>> sv/cpseg_check.sv
// Port-level checker for the segment projection block, bound to the top level.
// Depends on closest_point_on_segment_3d_top_assert.svh and cpseg_pkg.
`default_nettype none
`include "closest_point_on_segment_3d_top_assert.svh"

module cpseg_check (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [cpseg_pkg::CW-1:0]    m_q_x,
    input wire logic signed [cpseg_pkg::CW-1:0]    m_q_y,
    input wire logic signed [cpseg_pkg::CW-1:0]    m_q_z,
    input wire logic                               m_on_segment,
    input wire logic                               m_degenerate
);

    // A word that is held back keeps its payload.
    `CPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_q_x) && $stable(m_q_y) && $stable(m_q_z))

    // A zero-length segment never reports an interior projection.
    `CPS_ASSERT_NOW(a_degen, aclk, aresetn, m_valid && m_degenerate, !m_on_segment)

    // With the output register empty the pipeline never refuses a word.
    `CPS_ASSERT_NOW(a_ready, aclk, aresetn, !m_valid, s_ready)

    // Reset empties the pipeline by the next cycle.
    `CPS_ASSERT_RAW(a_reset, aclk, !aresetn, !m_valid)

endmodule

bind closest_point_on_segment_3d_top cpseg_check u_cpseg_check (.*);

`default_nettype wire
